### hdl/chrt_pkg.sv
`timescale 1ns / 1ps
package chrt_pkg;

	localparam int NUM_BUCKETS_DEF = 10;
	localparam int POOL_ENTRIES_DEF = 32;
	localparam int KEY_W = 40;
	localparam int NAME_W = 64;
	localparam int GRADE_W = 7;
	localparam int LINK_W = 6;
	localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_FIND = 2'd2;
	localparam logic [1:0] ACT_SCAN = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_SCAN_END = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [KEY_W-1:0] record_key;
		logic [NAME_W-1:0] record_name;
		logic [GRADE_W-1:0] record_grade;
		logic [GRADE_W-1:0] grade_low;
		logic [GRADE_W-1:0] grade_high;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [KEY_W-1:0] out_key;
		logic [NAME_W-1:0] out_name;
		logic [GRADE_W-1:0] out_grade;
		logic last_result;
	} res_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0] action;
		logic [LINK_W-1:0] bucket;
		logic [KEY_W-1:0] record_key;
		logic [NAME_W-1:0] record_name;
		logic [GRADE_W-1:0] record_grade;
		logic [GRADE_W-1:0] grade_low;
		logic [GRADE_W-1:0] grade_high;
	} cmd_t;

endpackage

### hdl/chained_hash_record_table_unit.sv
`timescale 1ns / 1ps
// Chained hash record table: insert, remove, find by key and grade range scan.
// Request channel: drive req and raise push; the request is taken on a rising
// edge with push high and full low. Result channel: while empty is low the
// oldest result stands on res; pop high on a clock edge takes it.
// Each request yields one result, except a range scan, which yields one
// result per matching record and then a terminator; last_result marks the
// final result of each request.
// The front accepts a request, works out the key remainder in three steps
// (byte folding, reciprocal multiply, subtract) and hands it off into a
// two-entry queue; it takes no new request until that hand-off. The back
// inserts at the head of the bucket without a walk, walks one chain for
// remove or find, and for a scan visits every bucket and every stored record
// and emits each match. The chain walk sets the rate, and the front works on
// the next key while the back walks a chain.
// Reset empties every bucket and frees every entry at once, with no sweep.
// A result not popped holds the back; the queue then fills and full rises.
module chained_hash_record_table_unit #(
	parameter int NUM_BUCKETS = chrt_pkg::NUM_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chrt_pkg::POOL_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input chrt_pkg::req_t req,
	input logic push,
	output logic full,
	output chrt_pkg::res_t res,
	output logic empty,
	input logic pop
);
	chrt_pkg::cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	chrt_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .push(push), .full(full),
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	chrt_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	chrt_back #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.res(res), .empty(empty), .pop(pop)
	);
endmodule

### hdl/chrt_front.sv
`timescale 1ns / 1ps
// Accept requests and work out the bucket in three steps: fold the key by
// byte weights, divide the folded value by reciprocal multiply, then subtract.
module chrt_front #(
	parameter int NUM_BUCKETS = chrt_pkg::NUM_BUCKETS_DEF
) (
	input logic clk,
	input logic arst_n,
	input chrt_pkg::req_t req,
	input logic push,
	output logic full,
	output chrt_pkg::cmd_t cmd,
	output logic cmd_valid,
	input logic cmd_ready
);
	localparam int LW = chrt_pkg::LINK_W;
	localparam logic [LW:0] NB = (LW+1)'(NUM_BUCKETS);
	// folded value stays below 5 * 255 * 63, so 17 bits
	localparam int FW = 17;
	localparam int RS = FW + $clog2(NUM_BUCKETS);
	localparam logic [FW:0] RM = (FW+1)'(((64'd1 << RS) + 64'(NUM_BUCKETS) - 64'd1) /
		64'(NUM_BUCKETS));
	localparam logic [FW-1:0] W0 = FW'(64'd1 % 64'(NUM_BUCKETS));
	localparam logic [FW-1:0] W1 = FW'((64'd1 << 8) % 64'(NUM_BUCKETS));
	localparam logic [FW-1:0] W2 = FW'((64'd1 << 16) % 64'(NUM_BUCKETS));
	localparam logic [FW-1:0] W3 = FW'((64'd1 << 24) % 64'(NUM_BUCKETS));
	localparam logic [FW-1:0] W4 = FW'((64'd1 << 32) % 64'(NUM_BUCKETS));

	localparam logic [1:0] P_FOLD = 2'd0;
	localparam logic [1:0] P_DIV = 2'd1;
	localparam logic [1:0] P_SUB = 2'd2;

	chrt_pkg::req_t req_q;
	logic busy_q, done_q;
	logic [1:0] ph_q;
	logic [FW-1:0] fold_q, quo_q;
	logic [LW-1:0] rem_q;
	logic [FW-1:0] fold, quo, rem_full;
	logic [2*FW:0] prod;

	assign full = busy_q;

	// fold the key bytes with their weights modulo the bucket count
	assign fold = FW'(req_q.record_key[7:0]) * W0 + FW'(req_q.record_key[15:8]) * W1 +
		FW'(req_q.record_key[23:16]) * W2 + FW'(req_q.record_key[31:24]) * W3 +
		FW'(req_q.record_key[39:32]) * W4;
	assign prod = (2*FW+1)'(fold_q) * (2*FW+1)'(RM);
	assign quo = FW'(prod >> RS);
	assign rem_full = fold_q - quo_q * FW'(NB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q <= P_FOLD;
			fold_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else if (!busy_q) begin
			if (push) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				ph_q <= P_FOLD;
			end
		end else if (!done_q) begin
			// advance one reduction step a cycle
			case (ph_q)
			P_FOLD: begin
				fold_q <= fold;
				ph_q <= P_DIV;
			end
			P_DIV: begin
				quo_q <= quo;
				ph_q <= P_SUB;
			end
			default: begin
				rem_q <= LW'(rem_full);
				done_q <= 1'b1;
			end
			endcase
		end else if (cmd_ready) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !busy_q) req_q <= req;
	end

	assign cmd_valid = busy_q && done_q;
	always_comb begin
		cmd.action = req_q.action;
		cmd.bucket = rem_q;
		cmd.record_key = req_q.record_key;
		cmd.record_name = req_q.record_name;
		cmd.record_grade = req_q.record_grade;
		cmd.grade_low = req_q.grade_low;
		cmd.grade_high = req_q.grade_high;
	end

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("command changed while waiting");
	a_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.bucket < NB[LW-1:0]) || (NB[LW] == 1'b1))
		else $error("bucket out of range");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> full)
		else $error("front not busy while offering");
`endif
endmodule

### hdl/chrt_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module chrt_queue (
	input logic clk,
	input logic arst_n,
	input chrt_pkg::cmd_t wr_data,
	input logic wr_valid,
	output logic wr_ready,
	output chrt_pkg::cmd_t rd_data,
	output logic rd_valid,
	input logic rd_ready
);
	chrt_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

`ifndef ASSERT_OFF
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
		else $error("pointers disagree with count");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && !rd_ready && !wr |=> rd_valid && $stable(rd_data))
		else $error("head lost");
`endif
endmodule

### hdl/chrt_back.sv
`timescale 1ns / 1ps
// Walk chains over the entry pool and emit results into a one-deep output stage.
module chrt_back #(
	parameter int NUM_BUCKETS = chrt_pkg::NUM_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chrt_pkg::POOL_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input chrt_pkg::cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_ready,
	output chrt_pkg::res_t res,
	output logic empty,
	input logic pop
);
	localparam int LW = chrt_pkg::LINK_W;
	localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [LW-1:0] NL = chrt_pkg::NULL_LINK;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	// pool memories, read registered
	logic [chrt_pkg::KEY_W-1:0] key_mem [POOL_ENTRIES];
	logic [chrt_pkg::NAME_W-1:0] name_mem [POOL_ENTRIES];
	logic [chrt_pkg::GRADE_W-1:0] grade_mem [POOL_ENTRIES];
	logic [LW-1:0] next_mem [POOL_ENTRIES];
	logic [chrt_pkg::KEY_W-1:0] rd_key_q;
	logic [chrt_pkg::NAME_W-1:0] rd_name_q;
	logic [chrt_pkg::GRADE_W-1:0] rd_grade_q;
	logic [LW-1:0] rd_next_q;

	logic [LW-1:0] head_q [NUM_BUCKETS];
	logic [POOL_ENTRIES-1:0] free_q;

	logic [2:0] state_q;
	chrt_pkg::cmd_t c_q;
	logic [LW-1:0] cur_q, prev_q;
	logic [LW:0] steps_q;
	logic [BW-1:0] bkt_q;
	logic [LW:0] nout_q;
	chrt_pkg::res_t out_q, pend_q;
	logic out_v_q;
	logic ret_q; // after emit go to idle (else resume scan)

	logic [PW:0] free_idx;
	logic any_free;
	logic link_ok, cap_ok, out_room, in_rng;
	logic [BW-1:0] cbkt;

	assign res = out_q;
	assign empty = !out_v_q;
	assign out_room = !out_v_q || pop;
	assign cmd_ready = state_q == S_IDLE;
	assign cbkt = c_q.bucket[BW-1:0];
	assign link_ok = cur_q != NL && {1'b0, cur_q} < (LW+1)'(POOL_ENTRIES);
	assign cap_ok = steps_q < (LW+1)'(POOL_ENTRIES);
	assign in_rng = rd_grade_q >= c_q.grade_low && rd_grade_q <= c_q.grade_high;

	// lowest free entry
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = POOL_ENTRIES-1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = (PW+1)'(i);
				any_free = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[cur_q[PW-1:0]];
		rd_name_q <= name_mem[cur_q[PW-1:0]];
		rd_grade_q <= grade_mem[cur_q[PW-1:0]];
		rd_next_q <= next_mem[cur_q[PW-1:0]];
		if (state_q == S_START && c_q.action == chrt_pkg::ACT_INSERT && any_free) begin
			key_mem[free_idx[PW-1:0]] <= c_q.record_key;
			name_mem[free_idx[PW-1:0]] <= c_q.record_name;
			grade_mem[free_idx[PW-1:0]] <= c_q.record_grade;
			next_mem[free_idx[PW-1:0]] <= head_q[cbkt];
		end else if (state_q == S_CHECK && c_q.action == chrt_pkg::ACT_REMOVE &&
				rd_key_q == c_q.record_key && prev_q != NL) begin
			next_mem[prev_q[PW-1:0]] <= rd_next_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q <= '1;
			for (int i = 0; i < NUM_BUCKETS; i++) head_q[i] <= NL;
			out_v_q <= 1'b0;
			out_q <= '0;
			pend_q <= '0;
			cur_q <= NL;
			prev_q <= NL;
			steps_q <= '0;
			bkt_q <= '0;
			nout_q <= '0;
			ret_q <= 1'b0;
		end else begin
			// load the output stage on emit, drop it when popped
			if (state_q == S_EMIT && out_room) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_q <= S_START;
			end
			S_START: begin
				ret_q <= 1'b1;
				prev_q <= NL;
				steps_q <= '0;
				nout_q <= '0;
				case (c_q.action)
				chrt_pkg::ACT_INSERT: begin
					if (any_free) begin
						free_q[free_idx[PW-1:0]] <= 1'b0;
						head_q[cbkt] <= LW'(free_idx);
						pend_q <= '{chrt_pkg::ST_DONE, '0, '0, '0, 1'b1};
					end else begin
						pend_q <= '{chrt_pkg::ST_FULL, '0, '0, '0, 1'b1};
					end
					state_q <= S_EMIT;
				end
				chrt_pkg::ACT_SCAN: begin
					bkt_q <= '0;
					cur_q <= head_q[0];
					state_q <= S_READ;
				end
				default: begin
					cur_q <= head_q[cbkt];
					state_q <= S_READ;
				end
				endcase
			end
			S_READ: begin
				// memory read of cur_q lands next cycle
				if (link_ok && cap_ok) begin
					state_q <= S_CHECK;
				end else if (c_q.action == chrt_pkg::ACT_SCAN) begin
					if (32'(bkt_q) == NUM_BUCKETS-1) begin
						pend_q <= '{chrt_pkg::ST_SCAN_END, '0, '0, '0, 1'b1};
						ret_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						bkt_q <= bkt_q + BW'(1);
						cur_q <= head_q[bkt_q + BW'(1)];
						steps_q <= '0;
					end
				end else begin
					pend_q <= '{chrt_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1};
					ret_q <= 1'b1;
					state_q <= S_EMIT;
				end
			end
			S_CHECK: begin
				steps_q <= steps_q + (LW+1)'(1);
				prev_q <= cur_q;
				cur_q <= rd_next_q;
				if (c_q.action == chrt_pkg::ACT_SCAN) begin
					if (in_rng && nout_q < (LW+1)'(POOL_ENTRIES)) begin
						pend_q <= '{chrt_pkg::ST_DONE, rd_key_q, rd_name_q, rd_grade_q, 1'b0};
						ret_q <= 1'b0;
						nout_q <= nout_q + (LW+1)'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_READ;
					end
				end else if (rd_key_q == c_q.record_key) begin
					ret_q <= 1'b1;
					state_q <= S_EMIT;
					if (c_q.action == chrt_pkg::ACT_FIND) begin
						pend_q <= '{chrt_pkg::ST_DONE, rd_key_q, rd_name_q, rd_grade_q, 1'b1};
					end else begin
						pend_q <= '{chrt_pkg::ST_DONE, '0, '0, '0, 1'b1};
						if (prev_q == NL) head_q[cbkt] <= rd_next_q;
						free_q[cur_q[PW-1:0]] <= 1'b1;
					end
				end else begin
					state_q <= S_READ;
				end
			end
			S_EMIT: begin
				if (out_room) begin
					out_q <= pend_q;
					state_q <= ret_q ? S_IDLE : S_READ;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !pop |=> out_v_q && $stable(out_q))
		else $error("result overwritten");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_room && ret_q |=> out_q.last_result)
		else $error("final result lacks last flag");
	a_scan_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nout_q <= (LW+1)'(POOL_ENTRIES))
		else $error("scan emitted too many");
`endif
endmodule

### verif/tb_chained_hash_record_table_unit.sv
`timescale 1ns / 1ps
module tb_chained_hash_record_table_unit;

	localparam int NBKT = chrt_pkg::NUM_BUCKETS_DEF;
	localparam int NPOOL = chrt_pkg::POOL_ENTRIES_DEF;
	localparam int KW = chrt_pkg::KEY_W;
	localparam int GW = chrt_pkg::GRADE_W;
	localparam int LW = chrt_pkg::LINK_W;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	chrt_pkg::req_t req = '0;
	logic push = 1'b0;
	logic full;
	chrt_pkg::res_t res;
	logic empty;
	logic pop = 1'b0;

	chained_hash_record_table_unit DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .push(push), .full(full),
		.res(res), .empty(empty), .pop(pop)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table shadow
	logic [LW-1:0] head_sh [NBKT];
	logic [KW-1:0] key_sh [NPOOL];
	logic [chrt_pkg::NAME_W-1:0] name_sh [NPOOL];
	logic [GW-1:0] grade_sh [NPOOL];
	logic [LW-1:0] next_sh [NPOOL];
	bit free_sh [NPOOL];

	chrt_pkg::res_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;
	bit hold_results = 1'b0;
	bit burst_mode = 1'b1;
	logic [KW-1:0] used_keys [$];

	function automatic void shadow_reset();
		foreach (head_sh[i]) head_sh[i] = chrt_pkg::NULL_LINK;
		foreach (free_sh[i]) free_sh[i] = 1'b1;
	endfunction

	function automatic void push_result(logic [1:0] st, int idx, logic lst);
		chrt_pkg::res_t r;
		r = '0;
		r.status = st;
		r.last_result = lst;
		if (idx >= 0) begin
			r.out_key = key_sh[idx];
			r.out_name = name_sh[idx];
			r.out_grade = grade_sh[idx];
		end
		expected_results.push_back(r);
	endfunction

	// work out the results of one request and update the shadow table
	function automatic void predict_table(chrt_pkg::req_t q);
		int b, n, slot, steps;
		logic [LW-1:0] cur, prev;
		b = int'(q.record_key % NBKT);
		case (q.action)
			chrt_pkg::ACT_INSERT: begin
				slot = -1;
				for (int i = NPOOL - 1; i >= 0; i--)
					if (free_sh[i]) slot = i;
				if (slot < 0) begin
					push_result(chrt_pkg::ST_FULL, -1, 1'b1);
				end else begin
					free_sh[slot] = 1'b0;
					key_sh[slot] = q.record_key;
					name_sh[slot] = q.record_name;
					grade_sh[slot] = q.record_grade;
					next_sh[slot] = head_sh[b];
					head_sh[b] = LW'(slot);
					push_result(chrt_pkg::ST_DONE, -1, 1'b1);
				end
			end
			chrt_pkg::ACT_REMOVE, chrt_pkg::ACT_FIND: begin
				cur = head_sh[b];
				prev = chrt_pkg::NULL_LINK;
				steps = 0;
				while (steps < NPOOL && cur != chrt_pkg::NULL_LINK && cur < NPOOL) begin
					if (key_sh[cur] == q.record_key) break;
					prev = cur;
					cur = next_sh[cur];
					steps++;
				end
				if (steps < NPOOL && cur != chrt_pkg::NULL_LINK && cur < NPOOL) begin
					if (q.action == chrt_pkg::ACT_FIND) begin
						push_result(chrt_pkg::ST_DONE, int'(cur), 1'b1);
					end else begin
						if (prev == chrt_pkg::NULL_LINK) head_sh[b] = next_sh[cur];
						else next_sh[prev] = next_sh[cur];
						free_sh[cur] = 1'b1;
						push_result(chrt_pkg::ST_DONE, -1, 1'b1);
					end
				end else begin
					push_result(chrt_pkg::ST_NOT_FOUND, -1, 1'b1);
				end
			end
			default: begin
				n = 0;
				for (int i = 0; i < NBKT; i++) begin
					cur = head_sh[i];
					for (steps = 0; steps < NPOOL && cur != chrt_pkg::NULL_LINK &&
							cur < NPOOL; steps++) begin
						if (grade_sh[cur] >= q.grade_low && grade_sh[cur] <= q.grade_high
								&& n < NPOOL) begin
							push_result(chrt_pkg::ST_DONE, int'(cur), 1'b0);
							n++;
						end
						cur = next_sh[cur];
					end
				end
				push_result(chrt_pkg::ST_SCAN_END, -1, 1'b1);
			end
		endcase
	endfunction

	// send one request, predicting at acceptance; push stays up for the next
	task automatic send_request(chrt_pkg::req_t q);
		req <= q;
		push <= 1'b1;
		do @(posedge clk); while (full);
		predict_table(q);
	endtask

	// random gap between bursts
	task automatic idle_gap();
		if (burst_mode && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic chrt_pkg::req_t make_req(logic [1:0] act, logic [KW-1:0] k,
			logic [GW-1:0] g, logic [GW-1:0] lo, logic [GW-1:0] hi);
		chrt_pkg::req_t q;
		q.action = act;
		q.record_key = k;
		q.record_name = {$urandom, $urandom};
		q.record_grade = g;
		q.grade_low = lo;
		q.grade_high = hi;
		return q;
	endfunction

	function automatic logic [KW-1:0] rand_key();
		return KW'({$urandom, $urandom});
	endfunction

	// extremes, duplicates, misses and empty scan
	task automatic test_directed();
		logic [KW-1:0] kmax;
		kmax = '1;
		send_request(make_req(chrt_pkg::ACT_FIND, 40'd5, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_REMOVE, 40'd5, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, '0, 7'd127));
		send_request(make_req(chrt_pkg::ACT_INSERT, 40'd0, 7'd0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_INSERT, kmax, 7'd127, '0, '0));
		send_request(make_req(chrt_pkg::ACT_INSERT, 40'd10, 7'd50, '0, '0));
		send_request(make_req(chrt_pkg::ACT_INSERT, 40'd10, 7'd51, '0, '0));
		send_request(make_req(chrt_pkg::ACT_INSERT, 40'd20, 7'd52, '0, '0));
		send_request(make_req(chrt_pkg::ACT_FIND, 40'd10, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_FIND, kmax, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_FIND, 40'd30, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, 7'd0, 7'd127));
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, 7'd51, 7'd52));
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, 7'd100, 7'd3));
		send_request(make_req(chrt_pkg::ACT_REMOVE, 40'd20, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_REMOVE, 40'd10, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_FIND, 40'd10, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_REMOVE, kmax, '0, '0, '0));
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, 7'd0, 7'd127));
		wait_drained();
	endtask

	// fill the pool past its limit, scan a full table, then empty it
	task automatic test_pool_full();
		logic [KW-1:0] keys [$];
		logic [KW-1:0] k;
		for (int i = 0; i < NPOOL + 2; i++) begin
			k = (i % 3 == 0) ? rand_key() : KW'($urandom_range(0, 60));
			keys.push_back(k);
			send_request(make_req(chrt_pkg::ACT_INSERT, k, 7'($urandom), '0, '0));
			idle_gap();
		end
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, 7'd0, 7'd127));
		foreach (keys[i]) begin
			send_request(make_req(chrt_pkg::ACT_REMOVE, keys[i], '0, '0, '0));
			idle_gap();
		end
		wait_drained();
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		hold_results = 1'b1;
		for (int i = 0; i < 12; i++)
			send_request(make_req(chrt_pkg::ACT_INSERT, KW'($urandom_range(0, 40)),
				7'($urandom), '0, '0));
		send_request(make_req(chrt_pkg::ACT_SCAN, '0, '0, 7'd0, 7'd127));
		push <= 1'b0;
		wait (hold_results == 1'b0);
		wait_drained();
	endtask

	// mostly keys already stored, with random scans and noise
	task automatic test_random();
		chrt_pkg::req_t q;
		int pick;
		for (int i = 0; i < 70; i++) begin
			pick = $urandom_range(0, 99);
			q = make_req(chrt_pkg::ACT_INSERT, rand_key(), 7'($urandom), 7'($urandom),
				7'($urandom));
			if (pick < 40) q.action = chrt_pkg::ACT_INSERT;
			else if (pick < 65) q.action = chrt_pkg::ACT_REMOVE;
			else if (pick < 90) q.action = chrt_pkg::ACT_FIND;
			else q.action = chrt_pkg::ACT_SCAN;
			if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
				q.record_key = used_keys[$urandom_range(0, used_keys.size() - 1)];
			else if ($urandom_range(0, 1)) q.record_key = KW'($urandom_range(0, 99));
			if (q.action == chrt_pkg::ACT_INSERT && used_keys.size() < 24)
				used_keys.push_back(q.record_key);
			if (q.action == chrt_pkg::ACT_SCAN && $urandom_range(0, 1)) begin
				q.grade_low = 7'($urandom_range(0, 60));
				q.grade_high = 7'($urandom_range(61, 127));
			end
			send_request(q);
			if (i == 35) wait_drained();
			if (i % 40 == 0) burst_mode = ~burst_mode;
			idle_gap();
		end
		wait_drained();
	endtask

	// long hold-off of the result side
	initial begin
		wait (hold_results == 1'b1);
		repeat (1500) @(posedge clk);
		hold_results = 1'b0;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (hold_results) pop <= 1'b0;
		else if ((cycles / 256) % 4 == 3) pop <= 1'b1;
		else pop <= ((cycles % 7) != 3) && ($urandom_range(0, 4) != 0);
	end

	// compare each accepted result
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", res);
			end else begin
				chrt_pkg::res_t e;
				e = expected_results.pop_front();
				if (res !== e) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p got %p", e, res);
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		shadow_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_full();
		test_backpressure();
		test_random();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
